// ===== design/mrlc_pkg.sv =====
`timescale 1ns / 1ps

package mrlc_pkg;

    // Operation codes of an input request
    localparam logic [1:0] FN_FEED  = 2'd0;
    localparam logic [1:0] FN_POP   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    // Line classification codes
    localparam logic [1:0] LR_NONE  = 2'd0;
    localparam logic [1:0] LR_OK    = 2'd1;
    localparam logic [1:0] LR_ERROR = 2'd2;

    // Event codes
    localparam logic [2:0] EV_LINK_UP   = 3'd0;
    localparam logic [2:0] EV_LINK_DOWN = 3'd1;
    localparam logic [2:0] EV_NET_UP    = 3'd2;
    localparam logic [2:0] EV_NET_DOWN  = 3'd3;
    localparam logic [2:0] EV_PEER_CONN = 3'd4;
    localparam logic [2:0] EV_PEER_DISC = 3'd5;

    // Characters
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Stored line head and number field
    localparam int HEAD_LEN   = 6;
    localparam int NUM_OFFSET = 6;
    localparam logic [14:0] HANDLE_MAX   = 15'h7FFF;
    localparam logic [15:0] HANDLE_RESET = 16'hFFFF;

    // Prefixes, first character in the top byte
    localparam logic [15:0] PFX_OK    = "OK";
    localparam logic [39:0] PFX_ERROR = "ERROR";
    localparam logic [47:0] PFX_UDCP  = "+UDCP:";
    localparam logic [23:0] PFX_UU    = "+UU";
    localparam logic [47:0] PFX_WLE   = "+UUWLE";
    localparam logic [47:0] PFX_WLD   = "+UUWLD";
    localparam logic [39:0] PFX_NU    = "+UUNU";
    localparam logic [39:0] PFX_ND    = "+UUND";
    localparam logic [47:0] PFX_DPC   = "+UUDPC";
    localparam logic [47:0] PFX_DPD   = "+UUDPD";

    // Line parser result for one request
    typedef struct packed {
        logic [1:0]  line_result;
        logic        ev_push;
        logic [2:0]  ev_code;
        logic [15:0] handle;
    } t_line_out;

    // Event queue request for one cycle
    typedef struct packed {
        logic       push;
        logic [2:0] push_code;
        logic       pop;
        logic       clear;
    } t_evq_req;

    // Event queue pop result
    typedef struct packed {
        logic       ev_valid;
        logic [2:0] ev_code;
    } t_evq_out;

    // Fixed-width part of a result item
    typedef struct packed {
        logic [1:0]  line_result;
        logic        event_valid;
        logic [2:0]  event_code;
        logic [15:0] peer_handle;
    } t_res_fix;

endpackage

// ===== design/mrlc_if.sv =====
`timescale 1ns / 1ps

// Input request channel
interface mrlc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// Result channel
interface mrlc_out_if #(
    parameter int CNT_W = 4
);
    logic               valid;
    logic               ready;
    logic [1:0]         line_result;
    logic               event_valid;
    logic [2:0]         event_code;
    logic signed [15:0] peer_handle;
    logic [CNT_W-1:0]   queued_events;

    modport source (output valid, output line_result, output event_valid,
                    output event_code, output peer_handle, output queued_events,
                    input ready);
    modport sink   (input valid, input line_result, input event_valid,
                    input event_code, input peer_handle, input queued_events,
                    output ready);
endinterface

// ===== design/mrlc_ram.sv =====
`timescale 1ns / 1ps

module mrlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mrlc_line.sv =====
`timescale 1ns / 1ps

module mrlc_line #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_func,
    input  logic [7:0]          i_data_byte,
    output mrlc_pkg::t_line_out o_line
);

    localparam int KW = $clog2(LINE_CAPACITY + 1);

    logic [7:0]    r_head [mrlc_pkg::HEAD_LEN];
    logic [7:0]    n_head [mrlc_pkg::HEAD_LEN];
    logic [KW-1:0] r_kept, n_kept;
    logic [14:0]   r_accum, n_accum;
    logic          r_running, n_running;
    logic [15:0]   r_handle, n_handle;
    logic [47:0]   w_head;

    assign w_head = {r_head[0], r_head[1], r_head[2], r_head[3], r_head[4], r_head[5]};

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept    <= '0;
            r_accum   <= '0;
            r_running <= 1'b1;
            r_handle  <= mrlc_pkg::HANDLE_RESET;
            for (int i = 0; i < mrlc_pkg::HEAD_LEN; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_kept    <= n_kept;
            r_accum   <= n_accum;
            r_running <= n_running;
            r_handle  <= n_handle;
            r_head    <= n_head;
        end
    end

    // Byte handling and classification at end of line
    always_comb begin
        logic [18:0] prod;
        logic        is_digit;
        logic        has3, has5, has6;

        n_head    = r_head;
        n_kept    = r_kept;
        n_accum   = r_accum;
        n_running = r_running;
        n_handle  = r_handle;
        o_line.line_result = mrlc_pkg::LR_NONE;
        o_line.ev_push     = 1'b0;
        o_line.ev_code     = mrlc_pkg::EV_LINK_UP;

        is_digit = (i_data_byte >= mrlc_pkg::CH_ZERO) && (i_data_byte <= mrlc_pkg::CH_NINE);
        prod = 19'({r_accum, 3'b000}) + 19'({r_accum, 1'b0}) + 19'(i_data_byte[3:0]);
        has3 = r_kept >= KW'(3);
        has5 = r_kept >= KW'(5);
        has6 = r_kept >= KW'(6);

        if (i_valid) begin
            unique case (i_func)
                mrlc_pkg::FN_FEED: begin
                    if (i_data_byte == mrlc_pkg::CH_LF) begin
                        if (r_kept == KW'(2) && w_head[47:32] == mrlc_pkg::PFX_OK) begin
                            o_line.line_result = mrlc_pkg::LR_OK;
                        end else if (has5 && w_head[47:8] == mrlc_pkg::PFX_ERROR) begin
                            o_line.line_result = mrlc_pkg::LR_ERROR;
                        end else if (has6 && w_head == mrlc_pkg::PFX_UDCP) begin
                            n_handle = {1'b0, r_accum};
                        end else if (has3 && w_head[47:24] == mrlc_pkg::PFX_UU) begin
                            o_line.ev_push = 1'b1;
                            if (has6 && w_head == mrlc_pkg::PFX_WLE) begin
                                o_line.ev_code = mrlc_pkg::EV_LINK_UP;
                            end else if (has6 && w_head == mrlc_pkg::PFX_WLD) begin
                                o_line.ev_code = mrlc_pkg::EV_LINK_DOWN;
                            end else if (has5 && w_head[47:8] == mrlc_pkg::PFX_NU) begin
                                o_line.ev_code = mrlc_pkg::EV_NET_UP;
                            end else if (has5 && w_head[47:8] == mrlc_pkg::PFX_ND) begin
                                o_line.ev_code = mrlc_pkg::EV_NET_DOWN;
                            end else if (has6 && w_head == mrlc_pkg::PFX_DPC) begin
                                o_line.ev_code = mrlc_pkg::EV_PEER_CONN;
                            end else if (has6 && w_head == mrlc_pkg::PFX_DPD) begin
                                o_line.ev_code = mrlc_pkg::EV_PEER_DISC;
                            end else begin
                                o_line.ev_push = 1'b0;
                            end
                        end
                        // new empty line
                        n_kept    = '0;
                        n_accum   = '0;
                        n_running = 1'b1;
                    end else if (i_data_byte != mrlc_pkg::CH_CR &&
                                 r_kept < KW'(LINE_CAPACITY)) begin
                        if (r_kept < KW'(mrlc_pkg::HEAD_LEN)) begin
                            n_head[r_kept[2:0]] = i_data_byte;
                        end
                        if (r_kept >= KW'(mrlc_pkg::NUM_OFFSET) && r_running) begin
                            if (is_digit) begin
                                n_accum = (prod > 19'(mrlc_pkg::HANDLE_MAX)) ?
                                          mrlc_pkg::HANDLE_MAX : prod[14:0];
                            end else begin
                                n_running = 1'b0;
                            end
                        end
                        n_kept = r_kept + 1'b1;
                    end
                end
                mrlc_pkg::FN_CLEAR: begin
                    n_kept    = '0;
                    n_accum   = '0;
                    n_running = 1'b1;
                end
                default: begin
                end
            endcase
        end

        o_line.handle = n_handle;
    end

endmodule

// ===== design/mrlc_evq.sv =====
`timescale 1ns / 1ps

module mrlc_evq #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mrlc_pkg::t_evq_req                 i_req,
    output mrlc_pkg::t_evq_out                 o_evq,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [QW-1:0] r_rd, n_rd;
    logic [QW-1:0] r_wr, n_wr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_byp_v;
    logic [2:0]    r_byp_d;
    logic [2:0]    w_ram_q;
    logic [2:0]    w_head;
    logic          w_we;

    // Event storage; read runs every cycle at the next head pointer
    mrlc_ram #(
        .WIDTH (3),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr),
        .i_wdata (i_req.push_code),
        .i_raddr (n_rd),
        .o_rdata (w_ram_q)
    );

    // A write to the entry being read is forwarded
    assign w_head = r_byp_v ? r_byp_d : w_ram_q;

    always_comb begin
        n_rd = r_rd;
        n_wr = r_wr;
        n_cnt = r_cnt;
        w_we = 1'b0;
        o_evq.ev_valid = 1'b0;
        o_evq.ev_code  = mrlc_pkg::EV_LINK_UP;
        if (i_req.clear) begin
            n_rd  = '0;
            n_wr  = '0;
            n_cnt = '0;
        end else if (i_req.pop) begin
            if (r_cnt != '0) begin
                o_evq.ev_valid = 1'b1;
                o_evq.ev_code  = w_head;
                n_rd  = (r_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
                n_cnt = r_cnt - 1'b1;
            end
        end else if (i_req.push) begin
            if (r_cnt < CW'(QUEUE_DEPTH)) begin
                w_we  = 1'b1;
                n_wr  = (r_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    assign o_count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_cnt   <= '0;
            r_byp_v <= 1'b0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_cnt   <= n_cnt;
            r_byp_v <= w_we && (r_wr == n_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_d <= i_req.push_code;
    end

endmodule

// ===== design/modem_response_line_classifier_core.sv =====
`timescale 1ns / 1ps

// A request is held in the input register, classified there and its result written to
// the result buffer. Throughput: one request per cycle while there is room; line state
// and queue pointers update in one step. A three-entry result buffer lets requests flow
// back to back; input stalls only once the stage and buffer hold three results.
// Reset (synchronous, active low): empty line, empty queue, peer handle -1, no results.
module modem_response_line_classifier_core #(
    parameter int LINE_CAPACITY = 128,
    parameter int QUEUE_DEPTH   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrlc_in_if.sink     i_in,
    mrlc_out_if.source  o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OB_DEPTH = 3;

    logic       r_in_valid;
    logic [1:0] r_func;
    logic [7:0] r_byte;
    logic       w_in_acc;

    mrlc_pkg::t_line_out w_line;
    mrlc_pkg::t_evq_req  w_req;
    mrlc_pkg::t_evq_out  w_evq;
    logic [CNT_W-1:0]    w_count;

    mrlc_pkg::t_res_fix r_ob_fix [OB_DEPTH];
    logic [CNT_W-1:0]   r_ob_cnt [OB_DEPTH];
    logic [1:0]         r_ob_rd, r_ob_wr, r_ob_n;
    logic               w_ob_pop;

    // Input register; room is counted over the stage and the result buffer
    assign i_in.ready = (2'(r_in_valid) + r_ob_n) < 2'(OB_DEPTH);
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= i_in.func;
            r_byte <= i_in.data_byte;
        end
    end

    mrlc_line #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_func      (r_func),
        .i_data_byte (r_byte),
        .o_line      (w_line)
    );

    // Queue requests for this step
    assign w_req.push      = w_line.ev_push;
    assign w_req.push_code = w_line.ev_code;
    assign w_req.pop       = r_in_valid && (r_func == mrlc_pkg::FN_POP);
    assign w_req.clear     = r_in_valid && (r_func == mrlc_pkg::FN_CLEAR);

    mrlc_evq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_evq   (w_evq),
        .o_count (w_count)
    );

    // Result buffer
    assign w_ob_pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_rd <= '0;
            r_ob_wr <= '0;
            r_ob_n  <= '0;
        end else begin
            if (r_in_valid) begin
                r_ob_wr <= (r_ob_wr == 2'(OB_DEPTH - 1)) ? '0 : r_ob_wr + 1'b1;
            end
            if (w_ob_pop) begin
                r_ob_rd <= (r_ob_rd == 2'(OB_DEPTH - 1)) ? '0 : r_ob_rd + 1'b1;
            end
            r_ob_n <= r_ob_n + 2'(r_in_valid) - 2'(w_ob_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_ob_fix[r_ob_wr].line_result <= w_line.line_result;
            r_ob_fix[r_ob_wr].event_valid <= w_evq.ev_valid;
            r_ob_fix[r_ob_wr].event_code  <= w_evq.ev_code;
            r_ob_fix[r_ob_wr].peer_handle <= w_line.handle;
            r_ob_cnt[r_ob_wr]             <= w_count;
        end
    end

    assign o_out.valid         = r_ob_n != '0;
    assign o_out.line_result   = r_ob_fix[r_ob_rd].line_result;
    assign o_out.event_valid   = r_ob_fix[r_ob_rd].event_valid;
    assign o_out.event_code    = r_ob_fix[r_ob_rd].event_code;
    assign o_out.peer_handle   = r_ob_fix[r_ob_rd].peer_handle;
    assign o_out.queued_events = r_ob_cnt[r_ob_rd];

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mrlc_pkg::*;

    localparam int LINE_CAP  = 128;
    localparam int Q_DEPTH   = 8;
    localparam int WORK_GOAL = 900;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // One input request and the status it should produce
    typedef struct {
        logic [1:0] fn;
        logic [7:0] ch;
    } t_req;

    typedef struct {
        logic [1:0]         line_result;
        logic               ev_valid;
        logic [2:0]         ev_code;
        logic signed [15:0] handle;
        logic [3:0]         count;
    } t_line_status;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrlc_in_if in_if();
    mrlc_out_if #(.CNT_W(4)) out_if();

    modem_response_line_classifier_core #(
        .LINE_CAPACITY(LINE_CAP),
        .QUEUE_DEPTH  (Q_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #10 i_clk = ~i_clk;

    // Requests waiting to be sent, statuses waiting to arrive
    t_req         pending_reqs[$];
    t_line_status awaited_status[$];

    // Predictor state: line head, number field, peer handle, event ring
    logic [7:0]         line_head[HEAD_LEN];
    int                 line_len;
    int                 num_acc;
    bit                 digits_on;
    logic signed [15:0] peer_id;
    logic [2:0]         ev_ring[Q_DEPTH];
    int                 ev_head;
    int                 ev_fill;

    // Tallies for the summary
    int errors, reqs_accepted, work_items;
    int n_ok, n_err, n_handle, n_queued, n_dropped, n_popped, n_clear;

    // Handshake and idling state
    bit   req_taken, res_taken;
    int   tx_gap, rx_wait;
    bit   tx_calm, rx_calm;
    bit   hold_on, hold_done;
    int   hold_count;
    bit   cr_noise;
    t_req next_req;
    t_line_status got_status, want_status;

    task automatic restart_line();
        line_len  = 0;
        num_acc   = 0;
        digits_on = 1'b1;
    endtask

    // Line head starts with the n-character prefix (first char in the top byte)
    function automatic bit head_is(logic [47:0] pfx, int n);
        if (line_len < n) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (line_head[i] != pfx[8*(n-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_event(logic [2:0] code);
        if (ev_fill >= Q_DEPTH) begin
            n_dropped++;
        end else begin
            ev_ring[(ev_head + ev_fill) % Q_DEPTH] = code;
            ev_fill++;
            n_queued++;
        end
    endtask

    // Predict the status produced by one request
    task automatic classify_request(input logic [1:0] fn, input logic [7:0] ch,
                                    output t_line_status st);
        st.line_result = LR_NONE;
        st.ev_valid    = 1'b0;
        st.ev_code     = EV_LINK_UP;
        case (fn)
            FN_FEED: begin
                if (ch == CH_LF) begin
                    if (line_len > 0) begin
                        if (line_len == 2 && head_is(PFX_OK, 2)) begin
                            st.line_result = LR_OK;
                            n_ok++;
                        end else if (head_is(PFX_ERROR, 5)) begin
                            st.line_result = LR_ERROR;
                            n_err++;
                        end else if (head_is(PFX_UDCP, 6)) begin
                            peer_id = {1'b0, num_acc[14:0]};
                            n_handle++;
                        end else if (head_is(PFX_UU, 3)) begin
                            if (head_is(PFX_WLE, 6))      push_event(EV_LINK_UP);
                            else if (head_is(PFX_WLD, 6)) push_event(EV_LINK_DOWN);
                            else if (head_is(PFX_NU, 5))  push_event(EV_NET_UP);
                            else if (head_is(PFX_ND, 5))  push_event(EV_NET_DOWN);
                            else if (head_is(PFX_DPC, 6)) push_event(EV_PEER_CONN);
                            else if (head_is(PFX_DPD, 6)) push_event(EV_PEER_DISC);
                        end
                    end
                    restart_line();
                end else if (ch != CH_CR && line_len < LINE_CAP) begin
                    if (line_len < HEAD_LEN) line_head[line_len] = ch;
                    // digits from offset 6 build the handle, saturating
                    if (line_len >= NUM_OFFSET && digits_on) begin
                        if (ch >= CH_ZERO && ch <= CH_NINE) begin
                            num_acc = num_acc * 10 + int'(ch - CH_ZERO);
                            if (num_acc > int'(HANDLE_MAX)) num_acc = int'(HANDLE_MAX);
                        end else begin
                            digits_on = 1'b0;
                        end
                    end
                    line_len++;
                end
            end
            FN_POP: begin
                if (ev_fill > 0) begin
                    st.ev_valid = 1'b1;
                    st.ev_code  = ev_ring[ev_head];
                    ev_head     = (ev_head + 1) % Q_DEPTH;
                    ev_fill--;
                    n_popped++;
                end
            end
            FN_CLEAR: begin
                restart_line();
                ev_head = 0;
                ev_fill = 0;
                n_clear++;
            end
            default: ;
        endcase
        st.handle = peer_id;
        st.count  = ev_fill[3:0];
    endtask

    task automatic report_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    // Stimulus builders
    task automatic queue_byte(logic [7:0] b);
        t_req r;
        if (cr_noise && $urandom_range(0, 15) == 0) begin
            r.fn = FN_FEED;
            r.ch = CH_CR;
            pending_reqs.push_back(r);
        end
        r.fn = FN_FEED;
        r.ch = b;
        pending_reqs.push_back(r);
        if (b != CH_CR) work_items++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_op(logic [1:0] fn);
        t_req r;
        r.fn = fn;
        r.ch = 8'($urandom_range(0, 255));
        pending_reqs.push_back(r);
        if (fn != FN_UNUSED) work_items++;
    endtask

    task automatic queue_junk(int n);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    // Sample both channels at the rising edge; predict on every accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            res_taken <= 1'b0;
        end else begin
            req_taken <= in_if.valid && in_if.ready;
            res_taken <= out_if.valid && out_if.ready;
            if (in_if.valid && in_if.ready) begin
                classify_request(in_if.func, in_if.data_byte, want_status);
                awaited_status.push_back(want_status);
                reqs_accepted++;
            end
            if (out_if.valid && out_if.ready) begin
                if (awaited_status.size() == 0) begin
                    errors++;
                    $display("%0t ns: status with nothing expected, got line %0d ev %0d/%0d",
                             $time, out_if.line_result, out_if.event_valid, out_if.event_code);
                end else begin
                    got_status = awaited_status.pop_front();
                    report_field("line_result", got_status.line_result, out_if.line_result);
                    report_field("event_valid", got_status.ev_valid, out_if.event_valid);
                    report_field("event_code", got_status.ev_code, out_if.event_code);
                    report_field("peer_handle", int'(got_status.handle),
                                 int'(out_if.peer_handle));
                    report_field("queued_events", got_status.count, out_if.queued_events);
                end
            end
        end
    end

    // Request driver: one request at a time, random gap after each unless in calm mode
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || req_taken) begin
            if (tx_gap > 0) begin
                in_if.valid <= 1'b0;
                tx_gap--;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                in_if.valid     <= 1'b1;
                in_if.func      <= next_req.fn;
                in_if.data_byte <= next_req.ch;
                if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once the run is under way
    always @(negedge i_clk) begin
        if (i_rst_n && !hold_done && reqs_accepted >= 400) begin
            if (hold_count < 150) begin
                hold_on <= 1'b1;
                hold_count++;
            end else begin
                hold_on   <= 1'b0;
                hold_done = 1'b1;
            end
        end
    end

    // Status receiver: random wait after each accepted status unless calm; not ready while hold_on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if (hold_on) begin
                out_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                out_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        string ev_text[6];
        string near_text[13];
        string big_text[4];
        int  kind, n, line_no;
        bit  fill_phase;

        ev_text   = '{"+UUWLE", "+UUWLD", "+UUNU", "+UUND", "+UUDPC", "+UUDPD"};
        near_text = '{"+UUW", "+UUWLX", "+UUN", "+UUNX", "+UUDP", "+UUDPX",
                      "+UU", "+UDC", "+UDCP", "ERRO", "O", "OKAY", "K"};
        big_text  = '{"32767", "32768", "65535", "999999"};

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.func      = FN_FEED;
        in_if.data_byte = 8'h00;
        out_if.ready    = 1'b0;

        // predictor reset
        for (int i = 0; i < HEAD_LEN; i++) line_head[i] = 8'h00;
        restart_line();
        peer_id = HANDLE_RESET;
        ev_head = 0;
        ev_fill = 0;

        // Directed: pop on empty queue, unused func, empty line, OK with CR,
        // one event popped, handle with no digits, clear, byte extremes
        cr_noise = 1'b0;
        queue_op(FN_POP);
        queue_op(FN_UNUSED);
        queue_byte(CH_LF);
        queue_text("OK");
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        queue_text("+UUNU");
        queue_byte(CH_LF);
        queue_op(FN_POP);
        queue_text("+UDCP:");
        queue_byte(CH_LF);
        queue_op(FN_CLEAR);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_LF);

        // Random: mostly well-formed lines with random content, some noise
        cr_noise   = 1'b1;
        line_no    = 0;
        fill_phase = 1'b1;
        while (work_items < WORK_GOAL) begin
            line_no++;
            if (line_no % 40 == 0) fill_phase = !fill_phase;
            if (line_no == 30 || line_no == 150) begin
                // oversized handle line: the final digits fall past the capacity
                queue_text("+UDCP:");
                for (int i = 0; i < LINE_CAP - NUM_OFFSET; i++) queue_byte(CH_ZERO);
                queue_text("7");
                queue_text("12");
                queue_byte(CH_LF);
            end else if (line_no == 90) begin
                // oversized error line
                queue_text("ERROR");
                for (int i = 0; i < LINE_CAP + 5; i++) begin
                    n = $urandom_range(0, 255);
                    queue_byte(n == int'(CH_LF) ? 8'h41 : 8'(n));
                end
                queue_byte(CH_LF);
            end else begin
                kind = $urandom_range(0, 15);
                if (fill_phase && kind >= 10 && kind <= 12) kind = 5;
                if (!fill_phase && kind >= 5 && kind <= 7 && $urandom_range(0, 1)) kind = 10;
                case (kind)
                    0, 1: begin
                        queue_text("OK");
                        if ($urandom_range(0, 3) == 0) queue_junk(1);
                        queue_byte(CH_LF);
                    end
                    2: begin
                        queue_text("ERROR");
                        if ($urandom_range(0, 1)) queue_text(": ");
                        queue_junk($urandom_range(0, 4));
                        queue_byte(CH_LF);
                    end
                    3: begin
                        queue_text("+UDCP:");
                        if ($urandom_range(0, 5) == 0) begin
                            queue_text(big_text[$urandom_range(0, 3)]);
                        end else begin
                            n = $urandom_range(0, 7);
                            for (int i = 0; i < n; i++)
                                queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                        end
                        if ($urandom_range(0, 2) == 0) queue_junk($urandom_range(1, 3));
                        queue_byte(CH_LF);
                    end
                    4: begin
                        // non-digit right after the prefix
                        queue_text("+UDCP:");
                        queue_text($urandom_range(0, 1) ? " 12" : ",5");
                        queue_byte(CH_LF);
                    end
                    5, 6, 7: begin
                        queue_text(ev_text[$urandom_range(0, 5)]);
                        if ($urandom_range(0, 1)) queue_junk($urandom_range(1, 4));
                        queue_byte(CH_LF);
                    end
                    8: begin
                        queue_text(near_text[$urandom_range(0, 12)]);
                        queue_byte(CH_LF);
                    end
                    9: begin
                        n = $urandom_range(0, 8);
                        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
                        queue_byte(CH_LF);
                    end
                    10, 11, 12: begin
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++) queue_op(FN_POP);
                    end
                    13: queue_op($urandom_range(0, 3) == 0 ? FN_CLEAR : FN_POP);
                    14: queue_op(FN_UNUSED);
                    default: queue_byte(CH_LF);
                endcase
            end
        end

        // Reset held, then released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() > 0 || in_if.valid) @(posedge i_clk);
        while (awaited_status.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d requests over %0d lines: %0d OK, %0d ERROR, %0d handle updates",
                 reqs_accepted, line_no, n_ok, n_err, n_handle);
        $display("Events: %0d queued, %0d dropped on full queue, %0d popped, %0d clears",
                 n_queued, n_dropped, n_popped, n_clear);
        if (errors == 0) begin
            $display("** modem_response_line_classifier_core: PASSED **");
        end else begin
            $display("** modem_response_line_classifier_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("** modem_response_line_classifier_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
design/mrlc_pkg.sv
design/mrlc_if.sv
design/mrlc_ram.sv
design/mrlc_line.sv
design/mrlc_evq.sv
design/modem_response_line_classifier_core.sv
dv/testbench.sv
